// File: rtl/core/jet_pkg.sv
`default_nettype none

package jet_pkg;

    // Field widths.
    localparam int COORD_W    = 11;
    localparam int COUNT_W    = 16;
    localparam int COLOR_W    = 32;
    localparam int Q_W        = 32;
    localparam int STEP_W     = 31;
    localparam int CONST_W    = 31;
    localparam int PROD_W     = 64;
    localparam int FRAC_BITS  = 28;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // 4.0 in Q8.56, one bit wider than a product so the squared magnitude cannot wrap.
    localparam logic [PROD_W:0] ESCAPE_BOUND = 65'h0_0400_0000_0000_0000;
    localparam logic [COLOR_W-1:0] COLOR_MULT = 32'd1899762;

    localparam logic signed [PROD_W-1:0] Q_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] Q_MIN = 64'shFFFF_FFFF_8000_0000;

    // Register values after reset.
    localparam logic [STEP_W-1:0]         RST_PIXEL_STEP  = 31'd894784;
    localparam logic signed [Q_W-1:0]     RST_ORIGIN_REAL = -32'sd536870912;
    localparam logic signed [Q_W-1:0]     RST_ORIGIN_IMAG = -32'sd536870912;
    localparam logic signed [CONST_W-1:0] RST_CONST_REAL  = '0;
    localparam logic signed [CONST_W-1:0] RST_CONST_IMAG  = '0;
    localparam logic [COUNT_W-1:0]        RST_ITER_LIMIT  = 16'd50;
    localparam logic [COLOR_W-1:0]        RST_INSIDE_COLOR = 32'd16777215;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PIXEL_STEP      = 3'd0,
        REG_ORIGIN_REAL     = 3'd1,
        REG_ORIGIN_IMAG     = 3'd2,
        REG_CONST_REAL      = 3'd3,
        REG_CONST_IMAG      = 3'd4,
        REG_ITERATION_LIMIT = 3'd5,
        REG_INSIDE_COLOR    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [STEP_W-1:0]         pixel_step;
        logic signed [Q_W-1:0]     origin_real;
        logic signed [Q_W-1:0]     origin_imag;
        logic signed [CONST_W-1:0] const_real;
        logic signed [CONST_W-1:0] const_imag;
        logic [COUNT_W-1:0]        iteration_limit;
        logic [COLOR_W-1:0]        inside_color;
    } cfg_t;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [2:0] {
        MSEL_COL,
        MSEL_ROW,
        MSEL_RR,
        MSEL_II,
        MSEL_RI,
        MSEL_COLOR
    } msel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_R,
        ST_MAP_I,
        ST_LOAD_I,
        ST_SQ_R,
        ST_SQ_I,
        ST_CROSS,
        ST_UPDATE,
        ST_COLOR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic  in_ready;
        logic  mul_en;
        msel_t mul_sel;
        logic  load_zr;
        logic  load_zi;
        logic  save_sr;
        logic  save_si;
        logic  update_z;
        logic  load_out;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic limit_hit;
        logic escaped;
        logic out_busy;
    } stat_t;

    // Clamp a wide signed value to the signed Q4.28 range.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > Q_MAX) begin
            r = Q_MAX[Q_W-1:0];
        end
        else if (v < Q_MIN) begin
            r = Q_MIN[Q_W-1:0];
        end
        else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/jet_ifs.sv
`default_nettype none

interface jet_pix_if import jet_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface jet_res_if import jet_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [COUNT_W-1:0] iter_count;
    logic [COLOR_W-1:0] pixel_color;

    modport source (output valid, output out_col, output out_row, output iter_count,
                    output pixel_color, input ready);
    modport sink (input valid, input out_col, input out_row, input iter_count,
                  input pixel_color, output ready);
endinterface

interface jet_cfg_if import jet_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/julia_escape_time_pixel_unit.sv
// A pixel is mapped to its start point (MAP_R, MAP_I, LOAD_I), then iterated until the limit
// is hit or the pixel escapes; an escape adds a COLOR step before FINISH loads the result.
// One pixel at a time: the next transfer can come in the cycle after the result is loaded; an
// iteration steps through SQ_R, SQ_I and CROSS on the single 32 x 32 multiplier, then UPDATE.
// Reset: rst_n is asynchronous and active low; it returns the sequencer to idle, empties the
// output register and loads every configuration register with its documented default.
`default_nettype none

module julia_escape_time_pixel_unit import jet_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    jet_pix_if.sink  pix,
    jet_res_if.source res,
    jet_cfg_if.sink  cfg
);

    // Configuration registers. Writes are always taken; software must write them only while the
    // unit is idle. The unit does not enforce this: there is no interlock against a pixel in flight.
    cfg_t cfg_q;

    assign cfg.ready = 1'b1;

    jet_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg.valid && cfg.ready),
        .wr_addr (cfg.addr),
        .wr_data (cfg.data),
        .cfg     (cfg_q)
    );

    // Sequencer.
    ctrl_t ctrl;
    stat_t stat;

    jet_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign pix.ready = ctrl.in_ready;

    logic pix_xfer;
    assign pix_xfer = pix.valid && pix.ready;

    // Pixel coordinates are held for the whole computation and passed through to the result.
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;

    always_ff @(posedge clk)
    begin
        if (pix_xfer)
        begin
            col_reg <= pix.pixel_col;
            row_reg <= pix.pixel_row;
        end
    end

    // Shared multiplier. Every product in the design goes through this one unit; the operand
    // select comes from the sequencer state. All operands are at most 32 bits, and the
    // unsigned ones are zero extended so they stay positive in the signed multiply.
    logic signed [Q_W-1:0]    zr_reg;
    logic signed [Q_W-1:0]    zi_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic signed [Q_W-1:0]    mul_a;
    logic signed [Q_W-1:0]    mul_b;
    logic signed [PROD_W-1:0] prod_q;

    always_comb
    begin
        unique case (ctrl.mul_sel)
            MSEL_COL:
            begin
                mul_a = $signed(Q_W'(col_reg));
                mul_b = $signed(Q_W'(cfg_q.pixel_step));
            end
            MSEL_ROW:
            begin
                mul_a = $signed(Q_W'(row_reg));
                mul_b = $signed(Q_W'(cfg_q.pixel_step));
            end
            MSEL_RR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            MSEL_II:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            MSEL_RI:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
            MSEL_COLOR:
            begin
                mul_a = $signed(Q_W'(count_reg));
                mul_b = $signed(COLOR_MULT);
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    jet_mul u_mul (
        .clk      (clk),
        .en       (ctrl.mul_en),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod_q)
    );

    // Start point: the registered coordinate product plus the origin, clamped to Q4.28.
    logic signed [PROD_W-1:0] map_r_sum;
    logic signed [PROD_W-1:0] map_i_sum;

    assign map_r_sum = prod_q + PROD_W'(cfg_q.origin_real);
    assign map_i_sum = prod_q + PROD_W'(cfg_q.origin_imag);

    // The squares are saved as the multiplier moves on to the next product. By the update
    // cycle the multiplier output holds zr*zi.
    logic signed [PROD_W-1:0] sr_reg;
    logic signed [PROD_W-1:0] si_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.save_sr)
        begin
            sr_reg <= prod_q;
        end
        if (ctrl.save_si)
        begin
            si_reg <= prod_q;
        end
    end

    // Escape test on the exact squared magnitude; both squares are nonnegative, so the sum is
    // taken unsigned with one guard bit.
    logic [PROD_W:0] mag_sq;
    assign mag_sq = {1'b0, sr_reg} + {1'b0, si_reg};

    // New iterate. Shifting right arithmetically rounds toward minus infinity; the doubled
    // cross product shifted by the fraction width equals the plain product shifted one less.
    logic signed [PROD_W-1:0] sq_diff;
    logic signed [PROD_W-1:0] nr_sum;
    logic signed [PROD_W-1:0] ni_sum;

    assign sq_diff = sr_reg - si_reg;
    assign nr_sum  = (sq_diff >>> FRAC_BITS) + PROD_W'(cfg_q.const_real);
    assign ni_sum  = (prod_q >>> (FRAC_BITS - 1)) + PROD_W'(cfg_q.const_imag);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_zr)
        begin
            zr_reg <= sat_q(map_r_sum);
        end
        else if (ctrl.update_z)
        begin
            zr_reg <= sat_q(nr_sum);
        end

        if (ctrl.load_zi)
        begin
            zi_reg <= sat_q(map_i_sum);
        end
        else if (ctrl.update_z)
        begin
            zi_reg <= sat_q(ni_sum);
        end
    end

    // Iteration counter, cleared when a pixel is taken in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (pix_xfer)
        begin
            count_reg <= '0;
        end
        else if (ctrl.update_z)
        begin
            count_reg <= count_reg + COUNT_W'(1);
        end
    end

    // Output register. It parts the two sides, so a new pixel may be taken while the previous
    // result still waits for its transfer.
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_col_reg;
    logic [COORD_W-1:0] out_row_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               limit_hit;

    assign limit_hit = (count_reg >= cfg_q.iteration_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            out_col_reg   <= col_reg;
            out_row_reg   <= row_reg;
            out_count_reg <= count_reg;
            // On escape the multiplier holds count times the color factor; keep its low bits.
            out_color_reg <= limit_hit ? cfg_q.inside_color : prod_q[COLOR_W-1:0];
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.out_col     = out_col_reg;
    assign res.out_row     = out_row_reg;
    assign res.iter_count  = out_count_reg;
    assign res.pixel_color = out_color_reg;

    // Status back to the sequencer.
    assign stat.in_valid  = pix.valid;
    assign stat.limit_hit = limit_hit;
    assign stat.escaped   = (mag_sq >= ESCAPE_BOUND);
    assign stat.out_busy  = out_valid_reg && !res.ready;

`ifndef ASSERT_OFF
    // A pixel transfer always starts a computation, so the unit is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        pix_xfer |=> !pix.ready)
        else $error("unit still ready right after a pixel transfer");

    // A result is never loaded over one that has not been transferred.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |-> !(out_valid_reg && !res.ready))
        else $error("result register overwritten before its transfer");

    // Loading a result always presents it on the next cycle.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |=> res.valid)
        else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// File: rtl/core/jet_cfg.sv
`default_nettype none

module jet_cfg import jet_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_ADDR_W-1:0] wr_addr,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_addr)
                REG_PIXEL_STEP:      cfg_next.pixel_step      = wr_data[STEP_W-1:0];
                REG_ORIGIN_REAL:     cfg_next.origin_real     = wr_data;
                REG_ORIGIN_IMAG:     cfg_next.origin_imag     = wr_data;
                REG_CONST_REAL:      cfg_next.const_real      = wr_data[CONST_W-1:0];
                REG_CONST_IMAG:      cfg_next.const_imag      = wr_data[CONST_W-1:0];
                REG_ITERATION_LIMIT: cfg_next.iteration_limit = wr_data[COUNT_W-1:0];
                REG_INSIDE_COLOR:    cfg_next.inside_color    = wr_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_step      <= RST_PIXEL_STEP;
            cfg_reg.origin_real     <= RST_ORIGIN_REAL;
            cfg_reg.origin_imag     <= RST_ORIGIN_IMAG;
            cfg_reg.const_real      <= RST_CONST_REAL;
            cfg_reg.const_imag      <= RST_CONST_IMAG;
            cfg_reg.iteration_limit <= RST_ITER_LIMIT;
            cfg_reg.inside_color    <= RST_INSIDE_COLOR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/core/jet_mul.sv
`default_nettype none

module jet_mul import jet_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [Q_W-1:0]    op_a,
    input  logic signed [Q_W-1:0]    op_b,
    output logic signed [PROD_W-1:0] prod_reg
);

    logic signed [PROD_W-1:0] prod_next;

    // Full signed 32 x 32 product, registered.
    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/jet_ctrl.sv
`default_nettype none

module jet_ctrl import jet_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctrl         = '0;
        ctrl.mul_sel = MSEL_COL;
        state_next   = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    state_next = ST_MAP_R;
                end
            end
            ST_MAP_R:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MSEL_COL;
                state_next   = ST_MAP_I;
            end
            ST_MAP_I:
            begin
                ctrl.load_zr = 1'b1;
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MSEL_ROW;
                state_next   = ST_LOAD_I;
            end
            ST_LOAD_I:
            begin
                ctrl.load_zi = 1'b1;
                state_next   = ST_SQ_R;
            end
            ST_SQ_R:
            begin
                if (stat.limit_hit)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    ctrl.mul_en  = 1'b1;
                    ctrl.mul_sel = MSEL_RR;
                    state_next   = ST_SQ_I;
                end
            end
            ST_SQ_I:
            begin
                ctrl.save_sr = 1'b1;
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MSEL_II;
                state_next   = ST_CROSS;
            end
            ST_CROSS:
            begin
                ctrl.save_si = 1'b1;
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MSEL_RI;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (stat.escaped)
                begin
                    state_next = ST_COLOR;
                end
                else
                begin
                    ctrl.update_z = 1'b1;
                    state_next    = ST_SQ_R;
                end
            end
            ST_COLOR:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MSEL_COLOR;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
